FILE: hw/rtl/opr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opr_pkg
// shared types, constants and fixed-point helpers of the pixel-to-ray pipeline
// ----------------------------------------------------------------------------
package opr_pkg;

  localparam int Q_FRAC    = 28;
  localparam int DIV_Q_W   = 32;   // quotient bits of the pipelined divider
  localparam int INV_NUM_W = 57;   // numerator width of the reciprocal (2^56)
  localparam int LAM_NUM_W = 60;   // numerator width of the lift factor
  localparam int ROOT_W    = 30;   // bits of the square root result
  localparam int ARG_W     = 31;   // root argument, non-negative q4.28

  localparam logic signed [63:0] Q_ONE   = 64'sd1 <<< Q_FRAC;
  localparam logic signed [63:0] Q_HALF  = 64'sd1 <<< (Q_FRAC - 1);
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_CENTER   = 3'd2,
    REG_MIRROR   = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        [31:0] scale_x;
    logic        [31:0] scale_y;
    logic        [31:0] center_xy;
    logic        [30:0] xi;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  // front end result handed to the reciprocal divider
  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] ddx;
    logic signed [31:0] ddy;
    logic        [31:0] dmag;
    logic               neg;
    logic               dz;
  } front_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(S32_MAX)) return S32_MAX;
    else if (v < 64'(S32_MIN)) return S32_MIN;
    else return v[31:0];
  endfunction

  // q4.28 product rounding: add half, floor, saturate
  function automatic logic signed [31:0] qrnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + Q_HALF) >>> Q_FRAC;
    return sat32(t);
  endfunction

endpackage

FILE: hw/rtl/opr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opr_front
// normalized-plane lift and distortion terms, twelve register stages
// ----------------------------------------------------------------------------
module opr_front import opr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] pixel_x,
  input  logic [15:0] pixel_y,
  input  cfg_t        cfg,
  output logic        out_valid,
  output front_t      out_data
);

  logic [11:0] vld_r;

  logic signed [16:0] dx, dy;
  logic signed [49:0] s1_px_r, s1_py_r;
  logic signed [31:0] s2_mx_r, s2_my_r;
  logic signed [63:0] s3_pxx_r, s3_pyy_r, s3_pxy_r, s3_pp1my_r, s3_pp2mx_r;
  logic signed [31:0] s3_mx_r, s3_my_r;
  logic signed [31:0] s4_mx2_r, s4_my2_r, s4_mxy_r, s4_qp1my_r, s4_qp2mx_r, s4_mx_r, s4_my_r;
  logic signed [31:0] s5_rho2_r, s5_mx2_r, s5_my2_r, s5_mxy_r, s5_qp1my_r, s5_qp2mx_r;
  logic signed [31:0] s5_mx_r, s5_my_r;
  logic signed [63:0] s6_pk1r_r, s6_prr_r, s6_pp1xy_r, s6_pp2xy_r;
  logic signed [31:0] s6_s2x_r, s6_s2y_r, s6_mx_r, s6_my_r, s6_qp1my_r, s6_qp2mx_r;
  logic signed [31:0] s7_qk1r_r, s7_rho4_r, s7_qp1xy_r, s7_qp2xy_r, s7_s2x_r, s7_s2y_r;
  logic signed [31:0] s7_mx_r, s7_my_r, s7_qp1my_r, s7_qp2mx_r;
  logic signed [63:0] s8_pk2r4_r, s8_pp2s_r, s8_pp1s_r;
  logic signed [31:0] s8_qk1r_r, s8_qp1xy_r, s8_qp2xy_r, s8_mx_r, s8_my_r, s8_qp1my_r;
  logic signed [31:0] s8_qp2mx_r;
  logic signed [31:0] s9_qk2r4_r, s9_qp2s_r, s9_qp1s_r, s9_qk1r_r, s9_qp1xy_r, s9_qp2xy_r;
  logic signed [31:0] s9_mx_r, s9_my_r, s9_qp1my_r, s9_qp2mx_r;
  logic signed [31:0] s10_rad_r, s10_den_r, s10_mx_r, s10_my_r;
  logic signed [33:0] s10_ex_r, s10_ey_r;
  logic signed [63:0] s11_prx_r, s11_pry_r;
  logic signed [33:0] s11_ex_r, s11_ey_r;
  logic signed [31:0] s11_mx_r, s11_my_r;
  logic        [31:0] s11_dmag_r;
  logic               s11_neg_r, s11_dz_r;
  front_t             s12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[10:0], in_valid};
    end
  end

  assign dx = $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.center_xy[15:0]});
  assign dy = $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.center_xy[31:16]});

  always_ff @(posedge clk) begin
    if (en) begin
      // pixel offset times (1-alpha)/f
      s1_px_r <= dx * $signed({1'b0, cfg.scale_x});
      s1_py_r <= dy * $signed({1'b0, cfg.scale_y});
      // q12.4 x q0.32 back to q4.28
      s2_mx_r <= sat32((64'(s1_px_r) + 64'sd128) >>> 8);
      s2_my_r <= sat32((64'(s1_py_r) + 64'sd128) >>> 8);
      s3_pxx_r   <= s2_mx_r * s2_mx_r;
      s3_pyy_r   <= s2_my_r * s2_my_r;
      s3_pxy_r   <= s2_mx_r * s2_my_r;
      s3_pp1my_r <= cfg.p1 * s2_my_r;
      s3_pp2mx_r <= cfg.p2 * s2_mx_r;
      s3_mx_r    <= s2_mx_r;
      s3_my_r    <= s2_my_r;
      s4_mx2_r   <= qrnd(s3_pxx_r);
      s4_my2_r   <= qrnd(s3_pyy_r);
      s4_mxy_r   <= qrnd(s3_pxy_r);
      s4_qp1my_r <= qrnd(s3_pp1my_r);
      s4_qp2mx_r <= qrnd(s3_pp2mx_r);
      s4_mx_r    <= s3_mx_r;
      s4_my_r    <= s3_my_r;
      s5_rho2_r  <= sat32(64'(s4_mx2_r) + 64'(s4_my2_r));
      s5_mx2_r   <= s4_mx2_r;
      s5_my2_r   <= s4_my2_r;
      s5_mxy_r   <= s4_mxy_r;
      s5_qp1my_r <= s4_qp1my_r;
      s5_qp2mx_r <= s4_qp2mx_r;
      s5_mx_r    <= s4_mx_r;
      s5_my_r    <= s4_my_r;
      s6_pk1r_r  <= cfg.k1 * s5_rho2_r;
      s6_prr_r   <= s5_rho2_r * s5_rho2_r;
      s6_pp1xy_r <= cfg.p1 * s5_mxy_r;
      s6_pp2xy_r <= cfg.p2 * s5_mxy_r;
      s6_s2x_r   <= sat32(64'(s5_rho2_r) + (64'(s5_mx2_r) <<< 1));
      s6_s2y_r   <= sat32(64'(s5_rho2_r) + (64'(s5_my2_r) <<< 1));
      s6_mx_r    <= s5_mx_r;
      s6_my_r    <= s5_my_r;
      s6_qp1my_r <= s5_qp1my_r;
      s6_qp2mx_r <= s5_qp2mx_r;
      s7_qk1r_r  <= qrnd(s6_pk1r_r);
      s7_rho4_r  <= qrnd(s6_prr_r);
      s7_qp1xy_r <= qrnd(s6_pp1xy_r);
      s7_qp2xy_r <= qrnd(s6_pp2xy_r);
      s7_s2x_r   <= s6_s2x_r;
      s7_s2y_r   <= s6_s2y_r;
      s7_mx_r    <= s6_mx_r;
      s7_my_r    <= s6_my_r;
      s7_qp1my_r <= s6_qp1my_r;
      s7_qp2mx_r <= s6_qp2mx_r;
      s8_pk2r4_r <= cfg.k2 * s7_rho4_r;
      s8_pp2s_r  <= cfg.p2 * s7_s2x_r;
      s8_pp1s_r  <= cfg.p1 * s7_s2y_r;
      s8_qk1r_r  <= s7_qk1r_r;
      s8_qp1xy_r <= s7_qp1xy_r;
      s8_qp2xy_r <= s7_qp2xy_r;
      s8_mx_r    <= s7_mx_r;
      s8_my_r    <= s7_my_r;
      s8_qp1my_r <= s7_qp1my_r;
      s8_qp2mx_r <= s7_qp2mx_r;
      s9_qk2r4_r <= qrnd(s8_pk2r4_r);
      s9_qp2s_r  <= qrnd(s8_pp2s_r);
      s9_qp1s_r  <= qrnd(s8_pp1s_r);
      s9_qk1r_r  <= s8_qk1r_r;
      s9_qp1xy_r <= s8_qp1xy_r;
      s9_qp2xy_r <= s8_qp2xy_r;
      s9_mx_r    <= s8_mx_r;
      s9_my_r    <= s8_my_r;
      s9_qp1my_r <= s8_qp1my_r;
      s9_qp2mx_r <= s8_qp2mx_r;
      // radial factor, jacobian denominator, tangential partial sums
      s10_rad_r <= sat32(64'(s9_qk1r_r) + 64'(s9_qk2r4_r));
      s10_den_r <= sat32(Q_ONE + (64'(s9_qk1r_r) <<< 2)
                         + (64'(s9_qk2r4_r) <<< 2) + (64'(s9_qk2r4_r) <<< 1)
                         + (64'(s9_qp1my_r) <<< 3) + (64'(s9_qp2mx_r) <<< 3));
      s10_ex_r  <= 34'(s9_qp2s_r) + (34'(s9_qp1xy_r) <<< 1);
      s10_ey_r  <= 34'(s9_qp1s_r) + (34'(s9_qp2xy_r) <<< 1);
      s10_mx_r  <= s9_mx_r;
      s10_my_r  <= s9_my_r;
      s11_prx_r  <= s10_mx_r * s10_rad_r;
      s11_pry_r  <= s10_my_r * s10_rad_r;
      s11_dz_r   <= (s10_den_r == 32'sd0);
      s11_neg_r  <= s10_den_r[31];
      s11_dmag_r <= s10_den_r[31] ? (32'd0 - s10_den_r) : s10_den_r;
      s11_ex_r   <= s10_ex_r;
      s11_ey_r   <= s10_ey_r;
      s11_mx_r   <= s10_mx_r;
      s11_my_r   <= s10_my_r;
      s12_r.ddx  <= sat32(64'(qrnd(s11_prx_r)) + 64'(s11_ex_r));
      s12_r.ddy  <= sat32(64'(qrnd(s11_pry_r)) + 64'(s11_ey_r));
      s12_r.mx   <= s11_mx_r;
      s12_r.my   <= s11_my_r;
      s12_r.dmag <= s11_dmag_r;
      s12_r.neg  <= s11_neg_r;
      s12_r.dz   <= s11_dz_r;
    end
  end

  assign out_valid = vld_r[11];
  assign out_data  = s12_r;

endmodule

FILE: hw/rtl/opr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opr_div
// pipelined restoring divider, round(num/den) half up, one quotient bit a stage
// ----------------------------------------------------------------------------
module opr_div import opr_pkg::*; #(
  parameter int NUM_W  = INV_NUM_W,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   num,
  input  logic [DIV_Q_W-1:0] den,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [DIV_Q_W-1:0] mag,
  output logic [SIDE_W-1:0]  out_side
);

  localparam int QW = DIV_Q_W;

  logic [NUM_W:0]   n2;
  logic [QW:0]      dd;
  logic             ovf;

  logic [QW:0]      vld_r;
  logic [QW:0]      rem_r  [0:QW];
  logic [QW-1:0]    lo_r   [0:QW];
  logic [QW-1:0]    q_r    [0:QW];
  logic [QW:0]      d_r    [0:QW];
  logic             ovf_r  [0:QW];
  logic [SIDE_W-1:0] side_r [0:QW];

  // rounding folded into the dividend: (2n + d) / 2d
  assign n2  = {num, 1'b0} + (NUM_W+1)'(den);
  assign dd  = {den, 1'b0};
  assign ovf = (n2 >> QW) >= (NUM_W+1)'(dd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= ovf ? '0 : (QW+1)'(n2 >> QW);
      lo_r[0]   <= n2[QW-1:0];
      q_r[0]    <= '0;
      d_r[0]    <= dd;
      ovf_r[0]  <= ovf;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [QW+1:0] t;
    logic          ge;
    assign t  = {rem_r[k], lo_r[k][QW-1]};
    assign ge = t >= {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? (QW+1)'(t - {1'b0, d_r[k]}) : (QW+1)'(t);
        lo_r[k+1]   <= {lo_r[k][QW-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][QW-2:0], ge};
        d_r[k+1]    <= d_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // quotient clamped to 2^31
  assign mag       = (ovf_r[QW] | q_r[QW][QW-1]) ? {1'b1, (QW-1)'(0)} : q_r[QW];
  assign out_valid = vld_r[QW];
  assign out_side  = side_r[QW];

endmodule

FILE: hw/rtl/opr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opr_sqrt
// pipelined integer square root of arg * 2^28, one result bit a stage
// ----------------------------------------------------------------------------
module opr_sqrt import opr_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ARG_W-1:0]  arg,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int RW    = ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int V_W   = 2 * ROOT_W;

  logic [RW:0]       vld_r;
  logic [REM_W-1:0]  rem_r  [0:RW];
  logic [RW-1:0]     res_r  [0:RW];
  logic [V_W-1:0]    v_r    [0:RW];
  logic [SIDE_W-1:0] side_r [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      res_r[0]  <= '0;
      v_r[0]    <= V_W'({arg, Q_FRAC'(0)});
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [REM_W+1:0] t;
    logic [RW+1:0]    trial;
    logic             ge;
    assign t     = {rem_r[k], v_r[k][V_W-1 -: 2]};
    assign trial = {res_r[k], 2'b01};
    assign ge    = t >= (REM_W+2)'(trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? REM_W'(t - (REM_W+2)'(trial)) : REM_W'(t);
        res_r[k+1]  <= {res_r[k][RW-2:0], ge};
        v_r[k+1]    <= {v_r[k][V_W-3:0], 2'b00};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign root      = res_r[RW];
  assign out_side  = side_r[RW];

endmodule

FILE: hw/rtl/omni_pixel_to_ray.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_pixel_to_ray
// unified-sphere omnidirectional camera: pixel coordinate to unnormalized ray
// ----------------------------------------------------------------------------
// usage
//   in_*  : one pixel per transfer, tdata = {pixel_y, pixel_x}, each q12.4
//   out_* : one ray per transfer, tdata = {ray_z, ray_y, ray_x} q4.28,
//           tuser = ray_valid (0 on a zero jacobian or a negative root term)
//   cfg_* : register writes; the user must write only while no pixel is in
//   flight, the block does not enforce it; one pixel per clock is accepted
//   unless a waiting ray is stalled; stages: front end 12, reciprocal
//   divider 33, sphere terms 7, square root 31, lift divider 1 + 33, ray scaling 3
//   the two dividers and the root resolve one bit per stage, which sets the
//   depth; every multiply is followed by a register
//   a stalled receiver freezes the whole pipeline, so in_tready drops in the
//   same cycle that out_tready is low with a ray waiting; nothing is lost
//   reset clears all valid bits and loads the register defaults (mirror 1.0)
// ----------------------------------------------------------------------------
module omni_pixel_to_ray import opr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // pixel_x [15:0], pixel_y [31:16]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // ray_x [31:0], ray_y [63:32], ray_z [95:64]
  output logic [0:0]  out_tuser,   // ray_valid [0]
  // register writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wr_data
);

  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] ddx;
    logic signed [31:0] ddy;
    logic               neg;
    logic               dz;
  } d1_side_t;

  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] r2;
    logic               bad;
  } sq_side_t;

  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic               bad;
  } d2_side_t;

  localparam int D1_W = $bits(d1_side_t);
  localparam int SQ_W = $bits(sq_side_t);
  localparam int D2_W = $bits(d2_side_t);

  cfg_t cfg_r;
  logic en;

  logic   fr_valid;
  front_t fr_data;

  logic               d1_valid;
  logic [DIV_Q_W-1:0] d1_mag;
  logic [D1_W-1:0]    d1_side_bits;
  d1_side_t           d1_in, d1_out;

  logic [6:0]         t_vld_r;
  logic signed [31:0] xi_s;
  logic signed [31:0] t1_inv_r, t1_mx_r, t1_my_r, t1_ddx_r, t1_ddy_r;
  logic               t1_dz_r;
  logic signed [63:0] t2_pix_r, t2_piy_r;
  logic signed [31:0] t2_mx_r, t2_my_r;
  logic               t2_dz_r;
  logic signed [31:0] t3_ux_r, t3_uy_r;
  logic               t3_dz_r;
  logic signed [63:0] t4_pux_r, t4_puy_r, t4_pxi_r;
  logic signed [31:0] t4_ux_r, t4_uy_r;
  logic               t4_dz_r;
  logic signed [31:0] t5_r2_r, t5_omx_r, t5_ux_r, t5_uy_r;
  logic               t5_dz_r;
  logic signed [63:0] t6_pa_r;
  logic signed [31:0] t6_r2_r, t6_ux_r, t6_uy_r;
  logic               t6_dz_r;
  logic signed [31:0] t7_arg_r, t7_r2_r, t7_ux_r, t7_uy_r;
  logic               t7_dz_r;
  logic               t7_bad;
  logic [ARG_W-1:0]   sq_arg;
  sq_side_t           sq_in, sq_out;

  logic               sq_valid;
  logic [ROOT_W-1:0]  sq_root;
  logic [SQ_W-1:0]    sq_side_bits;

  logic [31:0]        u1_sum;
  logic [32:0]        u1_dsum;
  logic               u1_vld_r;
  logic [LAM_NUM_W-1:0] u1_num_r;
  logic [31:0]        u1_den_r;
  d2_side_t           u1_side_r, d2_out;

  logic               d2_valid;
  logic [DIV_Q_W-1:0] d2_mag;
  logic [D2_W-1:0]    d2_side_bits;

  logic [2:0]         u_vld_r;
  logic signed [31:0] u2_lam_r, u2_ux_r, u2_uy_r;
  logic               u2_bad_r;
  logic signed [63:0] u3_plx_r, u3_ply_r;
  logic signed [31:0] u3_z_r;
  logic               u3_bad_r;
  logic signed [31:0] u4_rx_r, u4_ry_r, u4_rz_r;
  logic               u4_ok_r;

  // register file, mirror parameter resets to 1.0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= {32'd0, 32'd0, 32'd0, ARG_W'(Q_ONE), 32'd0, 32'd0, 32'd0, 32'd0};
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        REG_SCALE_X: cfg_r.scale_x   <= cfg_wr_data;
        REG_SCALE_Y: cfg_r.scale_y   <= cfg_wr_data;
        REG_CENTER:  cfg_r.center_xy <= cfg_wr_data;
        REG_MIRROR:  cfg_r.xi        <= cfg_wr_data[30:0];
        REG_K1:      cfg_r.k1        <= cfg_wr_data;
        REG_K2:      cfg_r.k2        <= cfg_wr_data;
        REG_P1:      cfg_r.p1        <= cfg_wr_data;
        REG_P2:      cfg_r.p2        <= cfg_wr_data;
        default:     cfg_r           <= cfg_r;
      endcase
    end
  end

  // whole pipeline advances unless a finished ray is held back
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign xi_s      = $signed({1'b0, cfg_r.xi});

  // normalized plane and distortion terms
  opr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .pixel_x  (in_tdata[15:0]),
    .pixel_y  (in_tdata[31:16]),
    .cfg      (cfg_r),
    .out_valid(fr_valid),
    .out_data (fr_data)
  );

  assign d1_in.mx  = fr_data.mx;
  assign d1_in.my  = fr_data.my;
  assign d1_in.ddx = fr_data.ddx;
  assign d1_in.ddy = fr_data.ddy;
  assign d1_in.neg = fr_data.neg;
  assign d1_in.dz  = fr_data.dz;

  // 1 / den in q4.28
  opr_div #(.NUM_W(INV_NUM_W), .SIDE_W(D1_W)) u_div_inv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fr_valid),
    .num      ({1'b1, (INV_NUM_W-1)'(0)}),
    .den      (fr_data.dmag),
    .in_side  (d1_in),
    .out_valid(d1_valid),
    .mag      (d1_mag),
    .out_side (d1_side_bits)
  );
  assign d1_out = d1_side_t'(d1_side_bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= '0;
    end else if (en) begin
      t_vld_r <= {t_vld_r[5:0], d1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // signed reciprocal, positive side tops out one below 2^31
      t1_inv_r <= d1_out.neg ? $signed(32'd0 - d1_mag)
                             : (d1_mag[31] ? S32_MAX : $signed(d1_mag));
      t1_mx_r  <= d1_out.mx;
      t1_my_r  <= d1_out.my;
      t1_ddx_r <= d1_out.ddx;
      t1_ddy_r <= d1_out.ddy;
      t1_dz_r  <= d1_out.dz;
      t2_pix_r <= t1_inv_r * t1_ddx_r;
      t2_piy_r <= t1_inv_r * t1_ddy_r;
      t2_mx_r  <= t1_mx_r;
      t2_my_r  <= t1_my_r;
      t2_dz_r  <= t1_dz_r;
      // undistorted point
      t3_ux_r  <= sat32(64'(t2_mx_r) - 64'(qrnd(t2_pix_r)));
      t3_uy_r  <= sat32(64'(t2_my_r) - 64'(qrnd(t2_piy_r)));
      t3_dz_r  <= t2_dz_r;
      t4_pux_r <= t3_ux_r * t3_ux_r;
      t4_puy_r <= t3_uy_r * t3_uy_r;
      t4_pxi_r <= xi_s * xi_s;
      t4_ux_r  <= t3_ux_r;
      t4_uy_r  <= t3_uy_r;
      t4_dz_r  <= t3_dz_r;
      t5_r2_r  <= sat32(64'(qrnd(t4_pux_r)) + 64'(qrnd(t4_puy_r)));
      t5_omx_r <= sat32(Q_ONE - 64'(qrnd(t4_pxi_r)));
      t5_ux_r  <= t4_ux_r;
      t5_uy_r  <= t4_uy_r;
      t5_dz_r  <= t4_dz_r;
      t6_pa_r  <= t5_omx_r * t5_r2_r;
      t6_r2_r  <= t5_r2_r;
      t6_ux_r  <= t5_ux_r;
      t6_uy_r  <= t5_uy_r;
      t6_dz_r  <= t5_dz_r;
      // root argument 1 + (1 - xi^2) r^2
      t7_arg_r <= sat32(Q_ONE + 64'(qrnd(t6_pa_r)));
      t7_r2_r  <= t6_r2_r;
      t7_ux_r  <= t6_ux_r;
      t7_uy_r  <= t6_uy_r;
      t7_dz_r  <= t6_dz_r;
    end
  end

  assign t7_bad    = t7_dz_r || t7_arg_r[31];
  assign sq_arg    = t7_bad ? '0 : t7_arg_r[ARG_W-1:0];
  assign sq_in.ux  = t7_ux_r;
  assign sq_in.uy  = t7_uy_r;
  assign sq_in.r2  = t7_r2_r;
  assign sq_in.bad = t7_bad;

  opr_sqrt #(.SIDE_W(SQ_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (t_vld_r[6]),
    .arg      (sq_arg),
    .in_side  (sq_in),
    .out_valid(sq_valid),
    .root     (sq_root),
    .out_side (sq_side_bits)
  );
  assign sq_out = sq_side_t'(sq_side_bits);

  // lift factor operands: (xi + root) / (1 + r^2), r^2 is never negative
  assign u1_sum  = {1'b0, cfg_r.xi} + 32'(sq_root);
  assign u1_dsum = 33'(Q_ONE) + {1'b0, sq_out.r2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_vld_r <= 1'b0;
    end else if (en) begin
      u1_vld_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_num_r      <= {u1_sum, Q_FRAC'(0)};
      u1_den_r      <= (u1_dsum[32:31] != 2'b00) ? S32_MAX : u1_dsum[31:0];
      u1_side_r.ux  <= sq_out.ux;
      u1_side_r.uy  <= sq_out.uy;
      u1_side_r.bad <= sq_out.bad;
    end
  end

  opr_div #(.NUM_W(LAM_NUM_W), .SIDE_W(D2_W)) u_div_lam (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (u1_vld_r),
    .num      (u1_num_r),
    .den      (u1_den_r),
    .in_side  (u1_side_r),
    .out_valid(d2_valid),
    .mag      (d2_mag),
    .out_side (d2_side_bits)
  );
  assign d2_out = d2_side_t'(d2_side_bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_vld_r <= '0;
    end else if (en) begin
      u_vld_r <= {u_vld_r[1:0], d2_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_lam_r <= d2_mag[31] ? S32_MAX : $signed(d2_mag);
      u2_ux_r  <= d2_out.ux;
      u2_uy_r  <= d2_out.uy;
      u2_bad_r <= d2_out.bad;
      u3_plx_r <= u2_lam_r * u2_ux_r;
      u3_ply_r <= u2_lam_r * u2_uy_r;
      u3_z_r   <= sat32(64'(u2_lam_r) - 64'(xi_s));
      u3_bad_r <= u2_bad_r;
      // output register, rejected rays are all zero
      u4_rx_r  <= u3_bad_r ? 32'sd0 : qrnd(u3_plx_r);
      u4_ry_r  <= u3_bad_r ? 32'sd0 : qrnd(u3_ply_r);
      u4_rz_r  <= u3_bad_r ? 32'sd0 : u3_z_r;
      u4_ok_r  <= !u3_bad_r;
    end
  end

  assign out_tvalid = u_vld_r[2];
  assign out_tdata  = {u4_rz_r, u4_ry_r, u4_rx_r};
  assign out_tuser  = u4_ok_r;

`ifndef SYNTHESIS
  // a held ray must freeze the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // a rejected ray carries all-zero components
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 96'd0)
    else $error("rejected ray with nonzero data");

  // reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

FILE: tb/sv/omni_pixel_to_ray_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_pixel_to_ray_tb
// self-checking bench for the pixel-to-ray unprojection pipeline
// ----------------------------------------------------------------------------
// each accepted pixel is run through a bit-exact fixed-point ray predictor
// using the bench's own copy of the registers. The expected rays wait in a
// queue, and every ray transfer is checked field by field against the oldest
// entry. Both stream sides idle and stall at random. Registers are changed
// only once the pipeline has drained.
// ----------------------------------------------------------------------------
module omni_pixel_to_ray_tb;
  import opr_pkg::*;

  localparam int  DRAIN_CYCLES = 140;      // pipeline depth plus margin
  localparam int  CYCLE_LIMIT  = 400000;
  localparam longint ONE_Q     = 64'sd1 <<< 28;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic               ok;
  } ray_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;      // pixel_x [15:0], pixel_y [31:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;          // ray_x [31:0], ray_y [63:32], ray_z [95:64]
  logic [0:0]  out_tuser;          // ray_valid [0]
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wr_data = '0;

  omni_pixel_to_ray i_dut (.*);

  always #2 clk = ~clk;

  // bench copy of the register file
  logic [31:0] lens_scale_x, lens_scale_y, lens_center;
  logic [30:0] lens_xi;
  logic signed [31:0] lens_k1, lens_k2, lens_p1, lens_p2;

  ray_t rays_due[$];
  int   n_errors = 0;
  int   n_pixels = 0;
  int   n_rays = 0;
  int   n_rejected = 0;
  int   n_cycles = 0;

  // ---- fixed-point helpers --------------------------------------------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // q4.28 product, round half up then floor
  function automatic longint qprod(longint a, longint b);
    return clip32((a * b + (64'sd1 <<< 27)) >>> 28);
  endfunction

  // rounded division, half away from zero
  function automatic longint qquot(longint num, longint den);
    logic neg;
    longint unsigned n, d, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    if (q > (64'd1 << 31)) q = 64'd1 << 31;
    return clip32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // ray for one pixel under the current lens registers
  function automatic ray_t unproject(logic [15:0] px, logic [15:0] py);
    ray_t r;
    longint k1, k2, p1, p2, xi, dx, dy, mx, my, mx2, my2, mxy, rho2, rho4;
    longint rad, ddx, ddy, den, inv, ux, uy, r2, arg, root, lam;
    k1 = lens_k1; k2 = lens_k2; p1 = lens_p1; p2 = lens_p2;
    xi = longint'(lens_xi);
    dx = longint'(px) - longint'(lens_center[15:0]);
    dy = longint'(py) - longint'(lens_center[31:16]);
    r = '{0, 0, 0, 1'b0};
    // lift to the normalized plane
    mx = clip32((dx * longint'(lens_scale_x) + 128) >>> 8);
    my = clip32((dy * longint'(lens_scale_y) + 128) >>> 8);
    // first-order distortion removal
    mx2 = qprod(mx, mx);
    my2 = qprod(my, my);
    mxy = qprod(mx, my);
    rho2 = clip32(mx2 + my2);
    rho4 = qprod(rho2, rho2);
    rad = clip32(qprod(k1, rho2) + qprod(k2, rho4));
    ddx = clip32(qprod(mx, rad) + qprod(p2, clip32(rho2 + 2 * mx2)) + 2 * qprod(p1, mxy));
    ddy = clip32(qprod(my, rad) + qprod(p1, clip32(rho2 + 2 * my2)) + 2 * qprod(p2, mxy));
    den = clip32(ONE_Q + 4 * qprod(k1, rho2) + 6 * qprod(k2, rho4)
                 + 8 * qprod(p1, my) + 8 * qprod(p2, mx));
    if (den == 0) return r;
    inv = qquot(ONE_Q * ONE_Q, den);
    ux = clip32(mx - qprod(inv, ddx));
    uy = clip32(my - qprod(inv, ddy));
    // lift onto the sphere
    r2 = clip32(qprod(ux, ux) + qprod(uy, uy));
    arg = clip32(ONE_Q + qprod(clip32(ONE_Q - qprod(xi, xi)), r2));
    if (arg < 0) return r;
    root = longint'(int_sqrt(longint'(arg) << 28));
    lam = qquot((xi + root) * ONE_Q, clip32(ONE_Q + r2));
    r.rx = 32'(qprod(lam, ux));
    r.ry = 32'(qprod(lam, uy));
    r.rz = 32'(clip32(lam - xi));
    r.ok = 1'b1;
    return r;
  endfunction

  // ---- monitors -------------------------------------------------------------
  always @(posedge clk) begin
    ray_t exp_ray;
    n_cycles <= n_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      n_rays <= n_rays + 1;
      if (rays_due.size() == 0) begin
        $display("%0t: unexpected ray transfer, actual %h/%b", $time, out_tdata, out_tuser);
        n_errors++;
      end else begin
        exp_ray = rays_due.pop_front();
        if (!out_tuser[0]) n_rejected <= n_rejected + 1;
        if (out_tdata[31:0] !== exp_ray.rx) begin
          $display("%0t: ray_x expected %h actual %h", $time, exp_ray.rx, out_tdata[31:0]);
          n_errors++;
        end
        if (out_tdata[63:32] !== exp_ray.ry) begin
          $display("%0t: ray_y expected %h actual %h", $time, exp_ray.ry, out_tdata[63:32]);
          n_errors++;
        end
        if (out_tdata[95:64] !== exp_ray.rz) begin
          $display("%0t: ray_z expected %h actual %h", $time, exp_ray.rz, out_tdata[95:64]);
          n_errors++;
        end
        if (out_tuser[0] !== exp_ray.ok) begin
          $display("%0t: ray_valid expected %b actual %b", $time, exp_ray.ok, out_tuser[0]);
          n_errors++;
        end
      end
    end
    // predict on every accepted pixel
    if (rst_n && in_tvalid && in_tready) begin
      rays_due.insert(rays_due.size(), unproject(in_tdata[15:0], in_tdata[31:16]));
      n_pixels <= n_pixels + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("omni_pixel_to_ray_tb: errors");
      $finish;
    end
  end

  // receiver backpressure: long ready stretches, short stalls, rare long ones
  int ready_hold = 0;
  always @(posedge clk) begin
    int pick;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(1, 25);
      end else if (pick < 95) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  // ---- stimulus helpers -----------------------------------------------------
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one pixel transfer; valid stays high into a back-to-back follow-up
  task automatic send_pixel(logic [15:0] px, logic [15:0] py, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_pixels();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // register write; the write strobe is dropped by finish_writes
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    case (idx)
      REG_SCALE_X: lens_scale_x = val;
      REG_SCALE_Y: lens_scale_y = val;
      REG_CENTER:  lens_center  = val;
      REG_MIRROR:  lens_xi      = val[30:0];
      REG_K1:      lens_k1      = val;
      REG_K2:      lens_k2      = val;
      REG_P1:      lens_p1      = val;
      REG_P2:      lens_p2      = val;
      default:     ;
    endcase
    @(posedge clk);
  endtask

  task automatic finish_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_lens(logic [31:0] sx, logic [31:0] sy, logic [31:0] c, logic [31:0] xi,
                          logic [31:0] k1, logic [31:0] k2, logic [31:0] p1, logic [31:0] p2);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_CENTER, c);
    write_reg(REG_MIRROR, xi);
    write_reg(REG_K1, k1);
    write_reg(REG_K2, k2);
    write_reg(REG_P1, p1);
    write_reg(REG_P2, p2);
    finish_writes();
  endtask

  // drain the pipeline before touching the registers
  task automatic drain();
    stop_pixels();
    wait (rays_due.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  // ---- tests ----------------------------------------------------------------
  // reset registers: zero scale collapses every pixel onto the axis
  task automatic test_reset_defaults();
    send_pixel(16'h0000, 16'h0000, 0);
    send_pixel(16'hffff, 16'hffff, 0);
    send_pixel(16'h5555, 16'haaaa, 1);
    drain();
  endtask

  // field extremes, xi of one, zero denominator, negative root argument
  task automatic test_special_cases();
    // undistorted lens with xi of one, centered at the origin, scale of 1/256
    set_lens(32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 32'h1000_0000,
             32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(16'h0000, 16'h0000, 0);
    send_pixel(16'h1000, 16'h0800, 0);
    send_pixel(16'hffff, 16'h0000, 0);
    send_pixel(16'h0000, 16'hffff, 2);
    drain();
    // zero denominator: p2 of -1.0 against mx of 0.125
    set_lens(32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 32'h1000_0000,
             32'h0, 32'h0, 32'h0, 32'hf000_0000);
    send_pixel(16'd512, 16'd0, 0);
    send_pixel(16'd511, 16'd0, 0);
    drain();
    // negative root argument: xi of 2 with r of 1
    set_lens(32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 32'h2000_0000,
             32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(16'd4096, 16'd0, 0);
    send_pixel(16'd1024, 16'd0, 0);
    send_pixel(16'd2000, 16'd2000, 0);
    drain();
    // register extremes: full scale, far center, largest xi, extreme coefficients
    set_lens(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_pixel(16'h0000, 16'h0000, 0);
    send_pixel(16'hffff, 16'hffff, 0);
    send_pixel(16'hfffe, 16'hffff, 0);
    drain();
    set_lens(32'h0000_0001, 32'hffff_ffff, 32'h0000_ffff, 32'h0000_0000,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_pixel(16'h0000, 16'h8000, 0);
    send_pixel(16'h8000, 16'h0000, 0);
    send_pixel(16'hffff, 16'h0001, 0);
    drain();
  endtask

  // realistic random lens; a few calls go wild
  task automatic random_lens(bit wild);
    logic [31:0] sx, sy, c, xi, k1, k2, p1, p2;
    if (wild) begin
      sx = $urandom(); sy = $urandom(); c = $urandom(); xi = $urandom();
      k1 = $urandom(); k2 = $urandom(); p1 = $urandom(); p2 = $urandom();
    end else begin
      sx = $urandom_range(32'h0020_0000, 32'h0200_0000);
      sy = $urandom_range(32'h0020_0000, 32'h0200_0000);
      c  = {16'($urandom_range(16'h1000, 16'h6000)), 16'($urandom_range(16'h1000, 16'h8000))};
      xi = $urandom_range(0, 32'h3000_0000);
      k1 = 32'($signed($urandom_range(0, 32'h0a00_0000)) - 32'sh0500_0000);
      k2 = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      p1 = 32'($signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000);
      p2 = 32'($signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000);
    end
    set_lens(sx, sy, c, xi, k1, k2, p1, p2);
  endtask

  // random pixels; mostly inside the image around the center, some anywhere
  task automatic test_random_frames(int frames, int per_frame, bit gapless);
    logic [15:0] px, py;
    for (int f = 0; f < frames; f++) begin
      random_lens(f % 4 == 3);
      for (int i = 0; i < per_frame; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          px = $urandom();
          py = $urandom();
        end else begin
          px = lens_center[15:0] + 16'($signed($urandom_range(0, 16'h4000)) - 16'sh2000);
          py = lens_center[31:16] + 16'($signed($urandom_range(0, 16'h4000)) - 16'sh2000);
        end
        send_pixel(px, py, gapless ? 0 : pick_gap());
        // sender holds off once mid-frame until the pipeline is empty
        if (i == per_frame / 2 && f == 0) begin
          stop_pixels();
          wait (rays_due.size() == 0);
        end
      end
      drain();
    end
  endtask

  initial begin
    lens_scale_x = '0; lens_scale_y = '0; lens_center = '0;
    lens_xi = 31'h1000_0000;
    lens_k1 = '0; lens_k2 = '0; lens_p1 = '0; lens_p2 = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_special_cases();
    test_random_frames(8, 55, 1'b0);
    test_random_frames(2, 60, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pixels and %0d rays (%0d rejected) over reset, extreme and",
             n_pixels, n_rays, n_rejected);
    $display("random lens settings with random gaps and backpressure");
    if (n_errors == 0 && rays_due.size() == 0) begin
      $display("omni_pixel_to_ray_tb: clean");
    end else begin
      $display("omni_pixel_to_ray_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/opr_pkg.sv
hw/rtl/opr_front.sv
hw/rtl/opr_div.sv
hw/rtl/opr_sqrt.sv
hw/rtl/omni_pixel_to_ray.sv
tb/sv/omni_pixel_to_ray_tb.sv
